FILE: design/keyed_slot_allocator_macros.svh
// Assertion macros for the keyed slot allocator.
`ifndef KEYED_SLOT_ALLOCATOR_MACROS_SVH
`define KEYED_SLOT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("keyed_slot_allocator: assertion failed");

// next-cycle implication
`define KSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("keyed_slot_allocator: assertion failed");

`else

`define KSA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/ksa_pkg.sv
// Shared constants, types and helpers of the keyed slot allocator.
`default_nettype none

package ksa_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int KEY_W      = 32;
	localparam int IDX_OUT_W  = 6;
	localparam int FREED_W    = 7;
	localparam int FREED_MAX  = 127;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_SWEEP = 1'b1;

	typedef enum logic [1:0] {
		STAT_FOUND   = 2'd0,
		STAT_CLAIMED = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_SWEPT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWEEP,
		ST_REPORT
	} state_t;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// low bits of a slot number as reported on the output
	function automatic logic [IDX_OUT_W-1:0] to_out_index(slot_t idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[IDX_OUT_W-1:0];
	endfunction

	// freed count, saturated to the output range
	function automatic logic [FREED_W-1:0] to_out_freed(cnt_t cnt);
		logic [31:0] wide;
		wide = 32'(cnt);
		return (wide > 32'(FREED_MAX)) ? FREED_W'(FREED_MAX) : wide[FREED_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: design/keyed_slot_allocator.sv
// Keyed slot allocator: associative slot lookup with mark-and-sweep release.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid, in_stall, opcode, volume_key         | in (stall out)
//  output  | out_valid, out_stall, slot_index, status,      | out (stall in)
//          | freed_count                                   |
//
//  Push: accept in idle, then a walk over the key memory one slot per cycle
//  that ends at the first match or once the last slot has been compared,
//  then the report state. Sweep: one slot per cycle over every slot. The
//  single read port of the key memory and the used/seen update port set
//  this pace. Reset clears the used and seen marks at once; keys need no
//  clearing. A waiting result sits in the output register; the block
//  stalls its input while an item is in work, and holds its report while
//  the output register is full and out_stall is high.
`default_nettype none
`include "keyed_slot_allocator_macros.svh"

module keyed_slot_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          opcode,
	input  wire logic [ksa_pkg::KEY_W-1:0]     volume_key,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [ksa_pkg::IDX_OUT_W-1:0]      slot_index,
	output logic [1:0]                         status,
	output logic [ksa_pkg::FREED_W-1:0]        freed_count
);
	import ksa_pkg::*;

	localparam slot_t LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
	localparam cnt_t  CNT_END   = CNT_W'(SLOT_COUNT);

	// sequencer
	state_t state_q, state_nxt;

	// per-slot marks (flip-flops, cleared by reset) and key memory
	logic [SLOT_COUNT-1:0] slot_used_q;
	logic [SLOT_COUNT-1:0] slot_seen_q;
	logic [KEY_W-1:0]      key_mem [SLOT_COUNT];

	// working registers
	logic [KEY_W-1:0] key_q;
	cnt_t             cnt_q;
	slot_t            cur_idx;
	logic             free_found_q;
	slot_t            free_idx_q;
	cnt_t             freed_q;
	slot_t            res_idx_q;
	status_t          res_stat_q;

	// scan pipeline: stage 1 holds the key read for idx_s1
	logic             vld_s1;
	slot_t            idx_s1;
	logic             used_s1;
	logic [KEY_W-1:0] rd_key_s1;

	// output register
	logic                 out_valid_q;
	logic [IDX_OUT_W-1:0] slot_index_q;
	status_t              status_q;
	logic [FREED_W-1:0]   freed_count_q;

	// control
	logic accept;
	logic issue;
	logic hit;
	logic last_s1;
	logic key_we;
	logic sweep_last;
	logic out_free;

	assign cur_idx    = cnt_q[SLOT_W-1:0];
	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign hit        = vld_s1 && used_s1 && (rd_key_s1 == key_q);
	assign last_s1    = vld_s1 && (idx_s1 == LAST_SLOT);
	assign sweep_last = (cur_idx == LAST_SLOT);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (opcode == OP_SWEEP) ? ST_SWEEP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit || last_s1) begin
					state_nxt = ST_REPORT;
				end
			end
			ST_SWEEP: begin
				if (sweep_last) begin
					state_nxt = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		key_we   = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SCAN: begin
				issue  = (cnt_q != CNT_END);
				key_we = !hit && last_s1 && free_found_q;
			end
			ST_SWEEP:  ;
			ST_REPORT: ;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// key memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[free_idx_q] <= key_q;
		end
		if (issue) begin
			rd_key_s1 <= key_mem[cur_idx];
		end
	end

	// used and seen marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_used_q <= '0;
			slot_seen_q <= '0;
		end else if (state_q == ST_SCAN) begin
			if (hit) begin
				slot_seen_q[idx_s1] <= 1'b1;
			end else if (key_we) begin
				slot_used_q[free_idx_q] <= 1'b1;
				slot_seen_q[free_idx_q] <= 1'b1;
			end
		end else if (state_q == ST_SWEEP) begin
			if (slot_used_q[cur_idx] && !slot_seen_q[cur_idx]) begin
				slot_used_q[cur_idx] <= 1'b0;
			end
			slot_seen_q[cur_idx] <= 1'b0;
		end
	end

	// walk counter, scan pipeline, free-slot tracking, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q        <= volume_key;
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			freed_q      <= '0;
		end else if (state_q == ST_SCAN) begin
			if (issue) begin
				cnt_q   <= cnt_q + 1'b1;
				idx_s1  <= cur_idx;
				used_s1 <= slot_used_q[cur_idx];
				if (!slot_used_q[cur_idx] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= cur_idx;
				end
			end
			if (hit) begin
				res_idx_q  <= idx_s1;
				res_stat_q <= STAT_FOUND;
			end else if (last_s1) begin
				res_idx_q  <= free_found_q ? free_idx_q : '0;
				res_stat_q <= free_found_q ? STAT_CLAIMED : STAT_FULL;
			end
		end else if (state_q == ST_SWEEP) begin
			cnt_q <= cnt_q + 1'b1;
			if (slot_used_q[cur_idx] && !slot_seen_q[cur_idx]) begin
				freed_q <= freed_q + 1'b1;
			end
			if (sweep_last) begin
				res_idx_q  <= '0;
				res_stat_q <= STAT_SWEPT;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_REPORT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_REPORT && out_free) begin
			slot_index_q  <= to_out_index(res_idx_q);
			status_q      <= res_stat_q;
			freed_count_q <= (res_stat_q == STAT_SWEPT) ? to_out_freed(freed_q) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot_index  = slot_index_q;
	assign status      = status_q;
	assign freed_count = freed_count_q;

	`KSA_ASSERT_NEXT(a_report_loads, clk, arst_n, (state_q == ST_REPORT) && out_free, out_valid_q && (state_q == ST_IDLE))
	`KSA_ASSERT_NOW(a_claim_free, clk, arst_n, key_we, !slot_used_q[free_idx_q])
	`KSA_ASSERT_NEXT(a_claim_marks, clk, arst_n, key_we, slot_used_q[$past(free_idx_q)] && slot_seen_q[$past(free_idx_q)])
	`KSA_ASSERT_NOW(a_full_zero, clk, arst_n, out_valid_q && (status_q == STAT_FULL), (slot_index_q == '0) && (freed_count_q == '0))

endmodule

`default_nettype wire
